// ===== design/mma_pkg.sv =====
// Shared types and constants of the multichannel moving average core.
`default_nettype none

package mma_pkg;

    localparam int CHANNELS    = 32;
    localparam int WINDOW      = 100;

    localparam int CH_W        = 5;
    localparam int SAMPLE_W    = 15;
    localparam int SUM_W       = 22;
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RING_DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]     channel_out;
        logic [SAMPLE_W-1:0] average;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_UPDATE,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/mma_front.sv =====
// Front end: accept samples, drop unknown channels, queue them for the back end.
`default_nettype none

module mma_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire mma_pkg::in_item_t item,
    output mma_pkg::in_item_t     head,
    output logic                  head_valid,
    input  wire logic             take
);

    mma_pkg::in_item_t                queue_reg [mma_pkg::QUEUE_DEPTH];
    logic [mma_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mma_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mma_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             in_range;
    logic                             wr_en;
    logic                             rd_en;

    assign full       = (count_reg == mma_pkg::QCNT_W'(mma_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];

    // Classify: a channel past the last one is accepted and dropped.
    assign in_range = (32'(item.channel) < 32'(mma_pkg::CHANNELS));
    assign wr_en    = push && !full && in_range;
    assign rd_en    = take && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == mma_pkg::QPTR_W'(mma_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == mma_pkg::QPTR_W'(mma_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

// ===== design/mma_div.sv =====
// Restoring divider: one quotient bit per cycle.
`default_nettype none

module mma_div
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mma_pkg::div_req_t req,
    output mma_pkg::div_rsp_t      rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [mma_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [mma_pkg::SUM_W-1:0]         quo_reg, quo_next;
    logic [mma_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [mma_pkg::CNT_W-1:0]         divisor_reg, divisor_next;
    logic [mma_pkg::CNT_W:0]           shifted;
    logic                              fits;

    assign shifted = {rem_reg, quo_reg[mma_pkg::SUM_W-1]};
    assign fits    = (shifted >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = mma_pkg::DIV_CNT_W'(mma_pkg::SUM_W - 1);
            quo_next     = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit, subtract where the divisor fits.
            rem_next = fits ? mma_pkg::CNT_W'(shifted - {1'b0, divisor_reg})
                            : shifted[mma_pkg::CNT_W-1:0];
            quo_next = {quo_reg[mma_pkg::SUM_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/mma_back.sv =====
// Back end: per-channel ring, running sums, averaging and result register.
`default_nettype none

module mma_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mma_pkg::in_item_t head,
    input  wire logic              head_valid,
    output logic                   take,
    output logic                   empty,
    input  wire logic              pop,
    output mma_pkg::out_item_t     result
);

    mma_pkg::back_state_t              state_reg, state_next;

    // Per-channel state, cleared at reset.
    logic [mma_pkg::CNT_W-1:0]         pos_reg  [mma_pkg::CHANNELS];
    logic [mma_pkg::CNT_W-1:0]         fill_reg [mma_pkg::CHANNELS];
    logic [mma_pkg::SUM_W-1:0]         sum_reg  [mma_pkg::CHANNELS];

    // Sample ring of all channels, one window per channel.
    logic [mma_pkg::SAMPLE_W-1:0]      ring [mma_pkg::RING_DEPTH];
    logic [mma_pkg::SAMPLE_W-1:0]      ring_rd_data_reg;

    // Item in progress.
    logic [mma_pkg::CH_W-1:0]          ch_reg, ch_next;
    logic [mma_pkg::SAMPLE_W-1:0]      sample_reg, sample_next;
    logic [mma_pkg::CNT_W-1:0]         pos_cur_reg, pos_cur_next;
    logic [mma_pkg::CNT_W-1:0]         fill_cur_reg, fill_cur_next;
    logic [mma_pkg::SUM_W-1:0]         sum_cur_reg, sum_cur_next;
    logic [mma_pkg::ADDR_W-1:0]        addr_reg, addr_next;

    logic                              out_valid_reg, out_valid_next;
    mma_pkg::out_item_t                out_item_reg, out_item_next;

    logic [mma_pkg::CH_IDX_W-1:0]      head_idx;
    logic [mma_pkg::CH_IDX_W-1:0]      cur_idx;
    logic                              ring_full;
    logic [mma_pkg::SUM_W-1:0]         sum_new;
    logic [mma_pkg::CNT_W-1:0]         fill_new;
    logic [mma_pkg::CNT_W-1:0]         pos_new;
    logic                              update;
    logic                              out_free;

    mma_pkg::div_req_t                 div_req;
    mma_pkg::div_rsp_t                 div_rsp;

    assign head_idx = head.channel[mma_pkg::CH_IDX_W-1:0];
    assign cur_idx  = ch_reg[mma_pkg::CH_IDX_W-1:0];
    assign update   = (state_reg == mma_pkg::BK_UPDATE);
    assign out_free = !out_valid_reg || pop;

    assign ring_full = (fill_cur_reg == mma_pkg::CNT_W'(mma_pkg::WINDOW));
    assign sum_new   = ring_full
                       ? sum_cur_reg - mma_pkg::SUM_W'(ring_rd_data_reg)
                         + mma_pkg::SUM_W'(sample_reg)
                       : sum_cur_reg + mma_pkg::SUM_W'(sample_reg);
    assign fill_new  = ring_full ? fill_cur_reg : fill_cur_reg + 1'b1;
    assign pos_new   = (pos_cur_reg == mma_pkg::CNT_W'(mma_pkg::WINDOW - 1))
                       ? '0 : pos_cur_reg + 1'b1;

    assign div_req.start    = update;
    assign div_req.dividend = sum_new;
    assign div_req.divisor  = fill_new;

    mma_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        take           = 1'b0;
        ch_next        = ch_reg;
        sample_next    = sample_reg;
        pos_cur_next   = pos_cur_reg;
        fill_cur_next  = fill_cur_reg;
        sum_cur_next   = sum_cur_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !pop;
        out_item_next  = out_item_reg;
        unique case (state_reg)
            mma_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    take          = 1'b1;
                    ch_next       = head.channel;
                    sample_next   = head.sample;
                    pos_cur_next  = pos_reg[head_idx];
                    fill_cur_next = fill_reg[head_idx];
                    sum_cur_next  = sum_reg[head_idx];
                    addr_next     = mma_pkg::ADDR_W'(head_idx)
                                    * mma_pkg::ADDR_W'(mma_pkg::WINDOW)
                                    + mma_pkg::ADDR_W'(pos_reg[head_idx]);
                    state_next    = mma_pkg::BK_READ;
                end
            end
            mma_pkg::BK_READ:
            begin
                state_next = mma_pkg::BK_UPDATE;
            end
            mma_pkg::BK_UPDATE:
            begin
                state_next = mma_pkg::BK_DIV;
            end
            mma_pkg::BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = mma_pkg::BK_OUT;
                end
            end
            mma_pkg::BK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.channel_out = ch_reg;
                    out_item_next.average     = div_rsp.quotient[mma_pkg::SAMPLE_W-1:0];
                    state_next                = mma_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mma_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mma_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < mma_pkg::CHANNELS; i++)
            begin
                pos_reg[i]  <= '0;
                fill_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (update)
            begin
                pos_reg[cur_idx]  <= pos_new;
                fill_reg[cur_idx] <= fill_new;
                sum_reg[cur_idx]  <= sum_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        sample_reg   <= sample_next;
        pos_cur_reg  <= pos_cur_next;
        fill_cur_reg <= fill_cur_next;
        sum_cur_reg  <= sum_cur_next;
        addr_reg     <= addr_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            ring[addr_reg] <= sample_reg;
        end
        ring_rd_data_reg <= ring[addr_reg];
    end

    assign empty  = !out_valid_reg;
    assign result = out_item_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == mma_pkg::BK_DIV))
        else $error("divider finished outside the divide state");

    a_divisor_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (div_req.divisor != '0
                           && div_req.divisor <= mma_pkg::CNT_W'(mma_pkg::WINDOW)))
        else $error("divider started with a bad fill count");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mma_pkg::BK_OUT && out_free) |=> (out_valid_reg
                                                        && state_reg == mma_pkg::BK_IDLE))
        else $error("finished average not placed in the result register");

endmodule

`default_nettype wire

// ===== design/multichannel_moving_average_core.sv =====
// Top level of the multichannel moving average core.
`default_nettype none

// Each transfer on the input side carries a channel number and a load sample
// (unsigned, 8 fraction bits, 25600 = 100.0 percent); the core answers with
// one result holding the same channel and the truncated mean of that
// channel's last WINDOW samples (fewer until the window has filled once).
// A channel number at or above CHANNELS is taken and dropped without a
// result. Both sides look like a queue: push/full in, empty/pop out. A short
// input queue holds pending samples while the back end works, and the
// finished average waits in its own result register, so new samples are
// taken while a result is still unread. In the back end each sample goes
// through a ring read and update, a bit-per-cycle division of the 22-bit
// running sum by the fill count, and the load of the result register, which
// waits while a result is unread; only then is the next sample taken. The
// sample rings need no clearing pass: an old entry is used only after a wrap.
module multichannel_moving_average_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire mma_pkg::in_item_t item,
    output logic                   empty,
    input  wire logic              pop,
    output mma_pkg::out_item_t     result
);

    // Queue head handed from the front end to the back end.
    mma_pkg::in_item_t head;
    logic              head_valid;
    logic              take;

    // Accept, classify and queue incoming samples.
    mma_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .head       (head),
        .head_valid (head_valid),
        .take       (take)
    );

    // Update ring and running sum, divide, hold the result until popped.
    mma_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .take       (take),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== bench/tb_multichannel_moving_average_core.sv =====
// Self-checking testbench of the multichannel moving average core.
`timescale 1ns / 100ps

module tb_multichannel_moving_average_core;

    localparam int MAX_REPORTS = 10;
    localparam int MAX_WAIT    = 16;
    // Long enough for the back end to finish one more sample, with slack.
    localparam int DRAIN_CYCLES = 64;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    mma_pkg::in_item_t  item;
    logic               empty;
    logic               pop;
    mma_pkg::out_item_t result;

    multichannel_moving_average_core DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Per-channel copy of the averaging state: ring, write slot, fill count
    // and running sum, at the widths the core uses.
    logic [mma_pkg::SAMPLE_W-1:0] ring_mem [mma_pkg::CHANNELS][mma_pkg::WINDOW];
    logic [mma_pkg::CNT_W-1:0]    wr_pos   [mma_pkg::CHANNELS];
    logic [mma_pkg::CNT_W-1:0]    fill_cnt [mma_pkg::CHANNELS];
    logic [mma_pkg::SUM_W-1:0]    sum_acc  [mma_pkg::CHANNELS];

    // Averages predicted for accepted samples, oldest first.
    mma_pkg::out_item_t expected_avgs[$];

    int  fail_count     = 0;
    int  mismatch_count = 0;
    int  sent_count     = 0;
    int  checked_count  = 0;
    bit  no_gaps        = 1'b0;
    int  hot_ch[4];

    // Store one sample into its channel and return the new truncated mean.
    // Once the window is full, drop the oldest sample from the sum first.
    function automatic mma_pkg::out_item_t advance_channel(input mma_pkg::in_item_t it);
        int unsigned               ch;
        logic [mma_pkg::SUM_W-1:0] acc;
        mma_pkg::out_item_t        avg;
        ch  = 32'(it.channel);
        acc = sum_acc[ch];
        if (fill_cnt[ch] == mma_pkg::CNT_W'(mma_pkg::WINDOW))
            acc = acc - mma_pkg::SUM_W'(ring_mem[ch][wr_pos[ch]]);
        else
            fill_cnt[ch] = fill_cnt[ch] + 1'b1;
        ring_mem[ch][wr_pos[ch]] = it.sample;
        acc         = acc + mma_pkg::SUM_W'(it.sample);
        sum_acc[ch] = acc;
        wr_pos[ch]  = (wr_pos[ch] == mma_pkg::CNT_W'(mma_pkg::WINDOW - 1))
                      ? '0 : wr_pos[ch] + 1'b1;
        avg.channel_out = it.channel;
        avg.average     = mma_pkg::SAMPLE_W'(acc / mma_pkg::SUM_W'(fill_cnt[ch]));
        return avg;
    endfunction

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Bias toward the edges of the range: zero, full scale, all ones.
    function automatic logic [mma_pkg::SAMPLE_W-1:0] draw_sample();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return mma_pkg::SAMPLE_W'(25600);
            3, 4:    return mma_pkg::SAMPLE_W'($urandom_range(0, 32767));
            default: return mma_pkg::SAMPLE_W'($urandom_range(0, 25600));
        endcase
    endfunction

    // Offer one sample, hold it until the transfer, then predict its result.
    // Leave push high on return so back-to-back transfers need no toggle.
    task automatic send_sample(input int ch, input logic [mma_pkg::SAMPLE_W-1:0] value);
        mma_pkg::in_item_t it;
        int                gap;
        it.channel = mma_pkg::CH_W'(ch);
        it.sample  = value;
        gap        = draw_wait();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        sent_count++;
        if (it.channel < mma_pkg::CHANNELS)
            expected_avgs.push_back(advance_channel(it));
    endtask

    // Compare one popped result with the oldest prediction.
    task automatic check_result(input mma_pkg::out_item_t got);
        mma_pkg::out_item_t want;
        if (expected_avgs.size() == 0)
        begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: result with nothing pending: channel %0d average %0d",
                         $realtime, got.channel_out, got.average);
            return;
        end
        want = expected_avgs.pop_front();
        checked_count++;
        if (got.channel_out !== want.channel_out || got.average !== want.average)
        begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display({"%0t: mismatch: expected channel %0d average %0d, ",
                          "got channel %0d average %0d"},
                         $realtime, want.channel_out, want.average,
                         got.channel_out, got.average);
        end
    endtask

    // Edges of both fields, the over-100-percent range and a few alternating
    // bit patterns so every input bit toggles early.
    task automatic test_field_extremes();
        send_sample(0, '0);
        send_sample(0, '1);
        send_sample(0, mma_pkg::SAMPLE_W'(25600));
        send_sample(31, '1);
        send_sample(31, mma_pkg::SAMPLE_W'(1));
        send_sample(31, '0);
        send_sample(21, mma_pkg::SAMPLE_W'(15'h5555));
        send_sample(10, mma_pkg::SAMPLE_W'(15'h2AAA));
        send_sample(21, mma_pkg::SAMPLE_W'(15'h2AAA));
        send_sample(10, mma_pkg::SAMPLE_W'(15'h5555));
        send_sample(16, mma_pkg::SAMPLE_W'(25601));
        send_sample(15, mma_pkg::SAMPLE_W'(12800));
        send_sample(0, mma_pkg::SAMPLE_W'(3));
    endtask

    // Drive one channel to a full window of all-ones samples and past the
    // wrap, back to back, so the sum peaks; then pull it down with zeros.
    task automatic test_saturated_window();
        no_gaps = 1'b1;
        repeat (mma_pkg::WINDOW + 5) send_sample(17, '1);
        no_gaps = 1'b0;
        repeat (6) send_sample(17, '0);
    endtask

    // Feed three of the hot channels about a window each, so the oldest-sample
    // subtraction starts to run with random content.
    task automatic test_window_wrap();
        foreach (hot_ch[i])
            hot_ch[i] = $urandom_range(0, mma_pkg::CHANNELS - 1);
        for (int n = 0; n < 300; n++)
            send_sample(hot_ch[$urandom_range(0, 2)], draw_sample());
    endtask

    // Mixed traffic over all channels, still leaning on the hot ones, with
    // a stretch of back-to-back transfers in the middle.
    task automatic test_random_mix();
        int ch;
        for (int n = 0; n < 520; n++)
        begin
            no_gaps = (n >= 200 && n < 280);
            ch = ($urandom_range(0, 9) < 6) ? hot_ch[$urandom_range(0, 3)]
                                            : $urandom_range(0, mma_pkg::CHANNELS - 1);
            send_sample(ch, draw_sample());
        end
        no_gaps = 1'b0;
    endtask

    // Pop side: wait a random number of cycles, then take one result.
    initial
    begin : result_side
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            check_result(result);
        end
    end

    initial
    begin : run_limit
        #3ms;
        $display("timeout: %0d averages still pending", expected_avgs.size());
        $display("tb_multichannel_moving_average_core failed");
        $finish;
    end

    initial
    begin : main
        int wrapped;
        push  = 1'b0;
        item  = '0;
        rst_n = 1'b0;
        for (int c = 0; c < mma_pkg::CHANNELS; c++)
        begin
            wr_pos[c]   = '0;
            fill_cnt[c] = '0;
            sum_acc[c]  = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_saturated_window();
        test_window_wrap();
        test_random_mix();
        push <= 1'b0;

        // Hold until every prediction is matched, then let the back end settle
        // so a stray extra result still gets caught.
        wait (expected_avgs.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        wrapped = 0;
        for (int c = 0; c < mma_pkg::CHANNELS; c++)
            if (fill_cnt[c] == mma_pkg::CNT_W'(mma_pkg::WINDOW))
                wrapped++;
        $display("Sent %0d samples and checked %0d averages; %0d channels filled %s",
                 sent_count, checked_count, wrapped, "their window.");
        $display("Mismatches or stray results: %0d.", fail_count);
        if (fail_count == 0 && expected_avgs.size() == 0)
            $display("tb_multichannel_moving_average_core passed");
        else
            $display("tb_multichannel_moving_average_core failed");
        $finish;
    end

endmodule
